// ===== hdl/c8ie_pkg.sv =====
package c8ie_pkg;

    localparam int ADDR_W     = 12;
    localparam int FONT_BYTES = 80;

    // Item opcodes.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_EXEC  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    // Instruction groups by top nibble.
    localparam logic [3:0] GRP_SYS  = 4'h0;
    localparam logic [3:0] GRP_JP   = 4'h1;
    localparam logic [3:0] GRP_CALL = 4'h2;
    localparam logic [3:0] GRP_SEI  = 4'h3;
    localparam logic [3:0] GRP_SNEI = 4'h4;
    localparam logic [3:0] GRP_SER  = 4'h5;
    localparam logic [3:0] GRP_LDI  = 4'h6;
    localparam logic [3:0] GRP_ADDI = 4'h7;
    localparam logic [3:0] GRP_ALU  = 4'h8;
    localparam logic [3:0] GRP_SNER = 4'h9;
    localparam logic [3:0] GRP_IDX  = 4'hA;
    localparam logic [3:0] GRP_JPV  = 4'hB;
    localparam logic [3:0] GRP_DRW  = 4'hD;
    localparam logic [3:0] GRP_MISC = 4'hF;

    localparam logic [11:0] SYS_CLS = 12'h0E0;
    localparam logic [11:0] SYS_RET = 12'h0EE;

    localparam logic [7:0] MISC_ADDI  = 8'h1E;
    localparam logic [7:0] MISC_FONT  = 8'h29;
    localparam logic [7:0] MISC_BCD   = 8'h33;
    localparam logic [7:0] MISC_STORE = 8'h55;
    localparam logic [7:0] MISC_LOAD  = 8'h65;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    typedef struct packed {
        logic       ok;
        logic       wr_flag;
        logic [7:0] value;
        logic       flag;
    } t_alu_res;

    function automatic logic [7:0] font_byte(input logic [6:0] idx);
        logic [7:0] b;
        case (idx)
            7'd0, 7'd4, 7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19,
            7'd22, 7'd25, 7'd27, 7'd29, 7'd30, 7'd32, 7'd34, 7'd35,
            7'd40, 7'd42, 7'd44, 7'd45, 7'd47, 7'd49, 7'd50, 7'd52,
            7'd60, 7'd64, 7'd70, 7'd72, 7'd74, 7'd75, 7'd77: b = 8'hF0;
            7'd1, 7'd2, 7'd3, 7'd20, 7'd21, 7'd33, 7'd41, 7'd43,
            7'd46, 7'd51, 7'd53, 7'd54, 7'd56, 7'd58, 7'd66, 7'd67,
            7'd68: b = 8'h90;
            7'd5, 7'd7, 7'd8, 7'd37: b = 8'h20;
            7'd6: b = 8'h60;
            7'd9: b = 8'h70;
            7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48: b = 8'h10;
            7'd13, 7'd26, 7'd31, 7'd61, 7'd62, 7'd63, 7'd71, 7'd73,
            7'd76, 7'd78, 7'd79: b = 8'h80;
            7'd38, 7'd39: b = 8'h40;
            7'd55, 7'd57, 7'd59, 7'd65, 7'd69: b = 8'hE0;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Decimal digits {hundreds, tens, units} of a byte.
    function automatic logic [11:0] bcd_digits(input logic [7:0] v);
        logic [1:0]  h;
        logic [7:0]  r;
        logic [15:0] p;
        logic [3:0]  t;
        logic [7:0]  u;
        h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        r = v - (8'(h) * 8'd100);
        p = 16'(r) * 16'd205;
        t = p[14:11];
        u = r - 8'({t, 3'b000}) - 8'({t, 1'b0});
        return {2'b00, h, t, u[3:0]};
    endfunction

endpackage

// ===== hdl/c8ie_alu.sv =====
module c8ie_alu (
    input  logic [3:0]         i_op,
    input  logic [7:0]         i_vx,
    input  logic [7:0]         i_vy,
    input  logic               i_quirk,
    output c8ie_pkg::t_alu_res o_res
);

    logic [8:0] sum;
    logic [7:0] src;

    assign sum = 9'(i_vx) + 9'(i_vy);
    // The original shift forms take their operand from VY.
    assign src = i_quirk ? i_vy : i_vx;

    always_comb begin
        o_res.ok      = 1'b1;
        o_res.wr_flag = 1'b1;
        o_res.value   = 8'h00;
        o_res.flag    = 1'b0;
        case (i_op)
            c8ie_pkg::ALU_MOV: begin
                o_res.wr_flag = 1'b0;
                o_res.value   = i_vy;
            end
            c8ie_pkg::ALU_OR: begin
                o_res.wr_flag = 1'b0;
                o_res.value   = i_vx | i_vy;
            end
            c8ie_pkg::ALU_AND: begin
                o_res.wr_flag = 1'b0;
                o_res.value   = i_vx & i_vy;
            end
            c8ie_pkg::ALU_XOR: begin
                o_res.wr_flag = 1'b0;
                o_res.value   = i_vx ^ i_vy;
            end
            c8ie_pkg::ALU_ADD: begin
                o_res.value = sum[7:0];
                o_res.flag  = sum[8];
            end
            c8ie_pkg::ALU_SUB: begin
                o_res.value = i_vx - i_vy;
                o_res.flag  = (i_vx >= i_vy);
            end
            c8ie_pkg::ALU_SUBN: begin
                o_res.value = i_vy - i_vx;
                o_res.flag  = (i_vy >= i_vx);
            end
            c8ie_pkg::ALU_SHR: begin
                o_res.value = {1'b0, src[7:1]};
                o_res.flag  = src[0];
            end
            c8ie_pkg::ALU_SHL: begin
                o_res.value = {src[6:0], 1'b0};
                o_res.flag  = src[7];
            end
            default: begin
                o_res.ok      = 1'b0;
                o_res.wr_flag = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/chip8_instruction_executor_top.sv =====
// Memory write and unused item opcodes go straight to the result; memory read first
// reads the byte. Instructions fetch 2 memory bytes, read VX and VY, then execute;
// BCD writes three digits, and store and load walk the registers over one RAM port.
// One item is in work at a time; a finished result waits in the output register.
// After reset a clearing pass over all 4096 addresses writes zeros and the hex font into
// memory and zeros the registers; no item is accepted until it ends.
module chip8_instruction_executor_top #(
    parameter int PROGRAM_BASE = 512,
    parameter int FONT_BASE    = 80,
    parameter int STACK_DEPTH  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [11:0] o_program_count,
    output logic [15:0] o_index_value,
    output logic [15:0] o_executed_word,
    output logic [7:0]  o_read_data,
    output logic        o_clear_screen,
    output logic        o_draw_request,
    output logic [7:0]  o_draw_x,
    output logic [7:0]  o_draw_y,
    output logic [3:0]  o_draw_height
);

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SIW = $clog2(STACK_DEPTH);
    localparam int MEM_DEPTH = 1 << c8ie_pkg::ADDR_W;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD, S_F2, S_F3, S_VX, S_VY, S_EXEC, S_RET,
        S_FLAG, S_BCD, S_ST, S_ST2, S_LD, S_LD2, S_DONE
    } t_state;

    t_state r_state;

    logic [7:0]  r_mem [MEM_DEPTH];
    logic [7:0]  r_rf  [16];
    logic [11:0] r_stk [STACK_DEPTH];

    logic [7:0]  r_mem_rd;
    logic [7:0]  r_rf_rd;
    logic [11:0] r_stk_rd;

    logic [11:0] r_clr_cnt;
    logic [11:0] r_pc;
    logic [15:0] r_i;
    logic [SPW-1:0] r_sp;
    logic        r_quirk;
    logic [7:0]  r_hi;
    logic [15:0] r_word;
    logic [7:0]  r_vx;
    logic [7:0]  r_vy;
    logic        r_flag;
    logic [3:0]  r_k;
    logic [1:0]  r_status;
    logic [7:0]  r_rd;
    logic        r_clr;
    logic        r_drw;
    logic        r_ov;

    logic        mem_we;
    logic [11:0] mem_wa;
    logic [7:0]  mem_wd;
    logic [11:0] mem_ra;
    logic        rf_we;
    logic [3:0]  rf_wa;
    logic [7:0]  rf_wd;
    logic [3:0]  rf_ra;
    logic        stk_we;
    logic [SIW-1:0] stk_ra;

    logic        accept;
    logic [15:0] fetch_word;
    logic [SPW-1:0] sp_m1;
    logic [11:0] font_off;
    logic [11:0] walk_addr;
    logic [11:0] bcd;
    logic [3:0]  bcd_digit;
    logic [3:0]  x_reg;
    c8ie_pkg::t_alu_res alu_res;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign fetch_word = {r_hi, r_mem_rd};
    assign sp_m1      = r_sp - 1'b1;
    assign font_off   = r_clr_cnt - 12'(FONT_BASE);
    assign walk_addr  = r_i[11:0] + 12'(r_k);
    assign x_reg      = r_word[11:8];
    assign bcd        = c8ie_pkg::bcd_digits(r_vx);
    assign stk_ra     = sp_m1[SIW-1:0];

    always_comb begin
        case (r_k[1:0])
            2'd0:    bcd_digit = bcd[11:8];
            2'd1:    bcd_digit = bcd[7:4];
            default: bcd_digit = bcd[3:0];
        endcase
    end

    c8ie_alu u_alu (
        .i_op    (r_word[3:0]),
        .i_vx    (r_vx),
        .i_vy    (r_vy),
        .i_quirk (r_quirk),
        .o_res   (alu_res)
    );

    // Memory, register file and stack port control.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = walk_addr;
        mem_wd = r_rf_rd;
        mem_ra = walk_addr;
        rf_we  = 1'b0;
        rf_wa  = x_reg;
        rf_wd  = r_mem_rd;
        rf_ra  = r_k;
        stk_we = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr_cnt;
                mem_wd = (font_off < 12'(c8ie_pkg::FONT_BYTES)) ?
                         c8ie_pkg::font_byte(font_off[6:0]) : 8'h00;
                rf_we  = (r_clr_cnt[11:4] == 8'd0);
                rf_wa  = r_clr_cnt[3:0];
                rf_wd  = 8'h00;
            end
            S_IDLE: begin
                mem_wa = i_address;
                mem_wd = i_write_data;
                mem_we = accept && (i_opcode == c8ie_pkg::OP_WRITE);
                mem_ra = (i_opcode == c8ie_pkg::OP_READ) ? i_address : r_pc;
            end
            S_F2: begin
                mem_ra = r_pc + 12'd1;
            end
            S_F3: begin
                // BNNN in the original form adds V0 instead of VX.
                rf_ra = (fetch_word[15:12] == c8ie_pkg::GRP_JPV && r_quirk) ?
                        4'd0 : fetch_word[11:8];
            end
            S_VX: begin
                rf_ra = r_word[7:4];
            end
            S_EXEC: begin
                case (r_word[15:12])
                    c8ie_pkg::GRP_LDI: begin
                        rf_we = 1'b1;
                        rf_wd = r_word[7:0];
                    end
                    c8ie_pkg::GRP_ADDI: begin
                        rf_we = 1'b1;
                        rf_wd = r_vx + r_word[7:0];
                    end
                    c8ie_pkg::GRP_ALU: begin
                        rf_we = alu_res.ok;
                        rf_wd = alu_res.value;
                    end
                    c8ie_pkg::GRP_CALL: begin
                        stk_we = (r_sp < SPW'(STACK_DEPTH));
                    end
                    default: ;
                endcase
            end
            S_FLAG: begin
                rf_we = 1'b1;
                rf_wa = 4'hF;
                rf_wd = {7'd0, r_flag};
            end
            S_BCD: begin
                mem_we = 1'b1;
                mem_wd = {4'd0, bcd_digit};
            end
            S_ST2: begin
                mem_we = 1'b1;
            end
            S_LD2: begin
                rf_we = 1'b1;
                rf_wa = r_k;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_mem_rd <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_wa] <= rf_wd;
        end
        r_rf_rd <= r_rf[rf_ra];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[r_sp[SIW-1:0]] <= r_pc;
        end
        r_stk_rd <= r_stk[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= 12'd0;
            r_pc      <= 12'(PROGRAM_BASE);
            r_i       <= 16'd0;
            r_sp      <= '0;
            r_quirk   <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_quirk <= i_cfg_wr_data;
            end
            // In S_DONE the output register is handled by that state alone.
            if (o_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 12'd1;
                    if (r_clr_cnt == 12'(MEM_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_status <= c8ie_pkg::ST_OK;
                        r_word   <= 16'd0;
                        r_rd     <= 8'd0;
                        r_clr    <= 1'b0;
                        r_drw    <= 1'b0;
                        r_vx     <= 8'd0;
                        r_vy     <= 8'd0;
                        r_k      <= 4'd0;
                        case (i_opcode)
                            c8ie_pkg::OP_READ: r_state <= S_RD;
                            c8ie_pkg::OP_EXEC: r_state <= S_F2;
                            default:           r_state <= S_DONE;
                        endcase
                    end
                end
                S_RD: begin
                    r_rd    <= r_mem_rd;
                    r_state <= S_DONE;
                end
                S_F2: begin
                    r_hi    <= r_mem_rd;
                    r_state <= S_F3;
                end
                S_F3: begin
                    r_word  <= fetch_word;
                    r_pc    <= r_pc + 12'd2;
                    r_state <= S_VX;
                end
                S_VX: begin
                    r_vx    <= r_rf_rd;
                    r_state <= S_VY;
                end
                S_VY: begin
                    r_vy    <= r_rf_rd;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_DONE;
                    case (r_word[15:12])
                        c8ie_pkg::GRP_SYS: begin
                            if (r_word[11:0] == c8ie_pkg::SYS_CLS) begin
                                r_clr <= 1'b1;
                            end else if (r_word[11:0] == c8ie_pkg::SYS_RET) begin
                                if (r_sp == '0) begin
                                    r_status <= c8ie_pkg::ST_UNDERFLOW;
                                end else begin
                                    r_sp    <= sp_m1;
                                    r_state <= S_RET;
                                end
                            end else begin
                                r_status <= c8ie_pkg::ST_UNKNOWN;
                            end
                        end
                        c8ie_pkg::GRP_JP: r_pc <= r_word[11:0];
                        c8ie_pkg::GRP_CALL: begin
                            if (r_sp >= SPW'(STACK_DEPTH)) begin
                                r_status <= c8ie_pkg::ST_OVERFLOW;
                            end else begin
                                r_sp <= r_sp + 1'b1;
                                r_pc <= r_word[11:0];
                            end
                        end
                        c8ie_pkg::GRP_SEI: begin
                            if (r_vx == r_word[7:0]) r_pc <= r_pc + 12'd2;
                        end
                        c8ie_pkg::GRP_SNEI: begin
                            if (r_vx != r_word[7:0]) r_pc <= r_pc + 12'd2;
                        end
                        c8ie_pkg::GRP_SER: begin
                            if (r_word[3:0] != 4'd0) begin
                                r_status <= c8ie_pkg::ST_UNKNOWN;
                            end else if (r_vx == r_vy) begin
                                r_pc <= r_pc + 12'd2;
                            end
                        end
                        c8ie_pkg::GRP_SNER: begin
                            if (r_word[3:0] != 4'd0) begin
                                r_status <= c8ie_pkg::ST_UNKNOWN;
                            end else if (r_vx != r_vy) begin
                                r_pc <= r_pc + 12'd2;
                            end
                        end
                        c8ie_pkg::GRP_LDI, c8ie_pkg::GRP_ADDI: ;
                        c8ie_pkg::GRP_ALU: begin
                            if (!alu_res.ok) begin
                                r_status <= c8ie_pkg::ST_UNKNOWN;
                            end else if (alu_res.wr_flag) begin
                                r_flag  <= alu_res.flag;
                                r_state <= S_FLAG;
                            end
                        end
                        c8ie_pkg::GRP_IDX: r_i <= {4'd0, r_word[11:0]};
                        c8ie_pkg::GRP_JPV: r_pc <= r_word[11:0] + 12'(r_vx);
                        c8ie_pkg::GRP_DRW: r_drw <= 1'b1;
                        c8ie_pkg::GRP_MISC: begin
                            case (r_word[7:0])
                                c8ie_pkg::MISC_ADDI: r_i <= r_i + 16'(r_vx);
                                c8ie_pkg::MISC_FONT: begin
                                    r_i <= 16'(FONT_BASE) + 16'({r_vx[3:0], 2'b00})
                                           + 16'(r_vx[3:0]);
                                end
                                c8ie_pkg::MISC_BCD:   r_state <= S_BCD;
                                c8ie_pkg::MISC_STORE: r_state <= S_ST;
                                c8ie_pkg::MISC_LOAD:  r_state <= S_LD;
                                default: r_status <= c8ie_pkg::ST_UNKNOWN;
                            endcase
                        end
                        default: r_status <= c8ie_pkg::ST_UNKNOWN;
                    endcase
                end
                S_RET: begin
                    r_pc    <= r_stk_rd;
                    r_state <= S_DONE;
                end
                S_FLAG: begin
                    r_state <= S_DONE;
                end
                S_BCD: begin
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd2) begin
                        r_state <= S_DONE;
                    end
                end
                S_ST, S_LD: begin
                    r_state <= (r_state == S_ST) ? S_ST2 : S_LD2;
                end
                S_ST2, S_LD2: begin
                    if (r_k == x_reg) begin
                        if (r_quirk) begin
                            r_i <= r_i + 16'(x_reg) + 16'd1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= (r_state == S_ST2) ? S_ST : S_LD;
                    end
                end
                S_DONE: begin
                    if (!r_ov || !i_out_stall) begin
                        r_ov            <= 1'b1;
                        o_status        <= r_status;
                        o_program_count <= r_pc;
                        o_index_value   <= r_i;
                        o_executed_word <= r_word;
                        o_read_data     <= r_rd;
                        o_clear_screen  <= r_clr;
                        o_draw_request  <= r_drw;
                        o_draw_x        <= r_drw ? r_vx : 8'd0;
                        o_draw_y        <= r_drw ? r_vy : 8'd0;
                        o_draw_height   <= r_drw ? r_word[3:0] : 4'd0;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("item accepted while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted item not taken into work");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_clear_screen && o_draw_request))
        else $error("clear and draw in one result");
`endif

endmodule

// ===== tb/sv/tb_chip8_instruction_executor_top.sv =====
module tb_chip8_instruction_executor_top;

    localparam int PROG_START  = 512;
    localparam int GLYPH_START = 80;
    localparam int RET_DEPTH   = 16;
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam logic [7:0] GLYPHS [80] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] addr;
        logic [7:0]  data;
    } cpu_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] pc;
        logic [15:0] idx;
        logic [15:0] word;
        logic [7:0]  rd;
        logic        clr;
        logic        drw;
        logic [7:0]  dx;
        logic [7:0]  dy;
        logic [3:0]  dh;
    } cpu_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_opcode = 2'd0;
    logic [11:0] i_address = 12'd0;
    logic [7:0]  i_write_data = 8'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic [11:0] o_program_count;
    logic [15:0] o_index_value;
    logic [15:0] o_executed_word;
    logic [7:0]  o_read_data;
    logic        o_clear_screen;
    logic        o_draw_request;
    logic [7:0]  o_draw_x;
    logic [7:0]  o_draw_y;
    logic [3:0]  o_draw_height;

    chip8_instruction_executor_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_opcode(i_opcode), .i_address(i_address), .i_write_data(i_write_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_program_count(o_program_count),
        .o_index_value(o_index_value), .o_executed_word(o_executed_word),
        .o_read_data(o_read_data), .o_clear_screen(o_clear_screen),
        .o_draw_request(o_draw_request), .o_draw_x(o_draw_x), .o_draw_y(o_draw_y),
        .o_draw_height(o_draw_height)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the CPU state.
    logic [7:0]  cpu_mem [4096];
    logic [7:0]  cpu_v [16];
    logic [11:0] cpu_pc;
    logic [15:0] cpu_i;
    logic [11:0] cpu_stack [RET_DEPTH];
    int          cpu_sp;
    logic        cpu_quirks;

    cpu_item_t   pending_items [$];
    cpu_result_t expected_results [$];
    int n_items = 0, n_results = 0, n_errors = 0;
    int n_calls = 0, n_overflow = 0, n_underflow = 0, n_unknown = 0;

    task automatic cpu_reset();
        foreach (cpu_mem[k]) cpu_mem[k] = 8'h00;
        for (int k = 0; k < 80; k++) cpu_mem[GLYPH_START + k] = GLYPHS[k];
        foreach (cpu_v[k]) cpu_v[k] = 8'h00;
        cpu_pc = 12'(PROG_START);
        cpu_i = 16'h0;
        cpu_sp = 0;
        cpu_quirks = 1'b0;
    endtask

    // Runs one item on the shadow CPU and queues it with its expected result.
    task automatic queue_item(input logic [1:0] op, input logic [11:0] a, input logic [7:0] d);
        cpu_item_t   it;
        cpu_result_t r;
        logic [15:0] w;
        logic [3:0]  x, y, n;
        logic [7:0]  nn, va, vb, res;
        logic [11:0] nnn;
        logic        f, wf;
        r = '0;
        it.op = op;
        it.addr = a;
        it.data = d;
        if (op == c8ie_pkg::OP_WRITE) begin
            cpu_mem[a] = d;
        end else if (op == c8ie_pkg::OP_READ) begin
            r.rd = cpu_mem[a];
        end else if (op == c8ie_pkg::OP_EXEC) begin
            w = {cpu_mem[cpu_pc], cpu_mem[cpu_pc + 12'd1]};
            r.word = w;
            cpu_pc = cpu_pc + 12'd2;
            x = w[11:8];
            y = w[7:4];
            n = w[3:0];
            nn = w[7:0];
            nnn = w[11:0];
            case (w[15:12])
                c8ie_pkg::GRP_SYS: begin
                    if (nnn == c8ie_pkg::SYS_CLS) r.clr = 1'b1;
                    else if (nnn == c8ie_pkg::SYS_RET) begin
                        if (cpu_sp == 0) r.status = c8ie_pkg::ST_UNDERFLOW;
                        else begin
                            cpu_sp--;
                            cpu_pc = cpu_stack[cpu_sp];
                        end
                    end else r.status = c8ie_pkg::ST_UNKNOWN;
                end
                c8ie_pkg::GRP_JP: cpu_pc = nnn;
                c8ie_pkg::GRP_CALL: begin
                    if (cpu_sp >= RET_DEPTH) r.status = c8ie_pkg::ST_OVERFLOW;
                    else begin
                        cpu_stack[cpu_sp] = cpu_pc;
                        cpu_sp++;
                        cpu_pc = nnn;
                    end
                end
                c8ie_pkg::GRP_SEI: if (cpu_v[x] == nn) cpu_pc = cpu_pc + 12'd2;
                c8ie_pkg::GRP_SNEI: if (cpu_v[x] != nn) cpu_pc = cpu_pc + 12'd2;
                c8ie_pkg::GRP_SER: begin
                    if (n != 4'h0) r.status = c8ie_pkg::ST_UNKNOWN;
                    else if (cpu_v[x] == cpu_v[y]) cpu_pc = cpu_pc + 12'd2;
                end
                c8ie_pkg::GRP_LDI: cpu_v[x] = nn;
                c8ie_pkg::GRP_ADDI: cpu_v[x] = cpu_v[x] + nn;
                c8ie_pkg::GRP_ALU: begin
                    va = cpu_v[x];
                    vb = cpu_v[y];
                    wf = 1'b1;
                    res = 8'h00;
                    f = 1'b0;
                    case (n)
                        c8ie_pkg::ALU_MOV: begin cpu_v[x] = vb; wf = 1'b0; end
                        c8ie_pkg::ALU_OR:  begin cpu_v[x] = va | vb; wf = 1'b0; end
                        c8ie_pkg::ALU_AND: begin cpu_v[x] = va & vb; wf = 1'b0; end
                        c8ie_pkg::ALU_XOR: begin cpu_v[x] = va ^ vb; wf = 1'b0; end
                        c8ie_pkg::ALU_ADD: {f, res} = {1'b0, va} + {1'b0, vb};
                        c8ie_pkg::ALU_SUB: begin res = va - vb; f = (va >= vb); end
                        c8ie_pkg::ALU_SUBN: begin res = vb - va; f = (vb >= va); end
                        c8ie_pkg::ALU_SHR: begin
                            if (cpu_quirks) va = vb;
                            f = va[0];
                            res = va >> 1;
                        end
                        c8ie_pkg::ALU_SHL: begin
                            if (cpu_quirks) va = vb;
                            f = va[7];
                            res = va << 1;
                        end
                        default: begin r.status = c8ie_pkg::ST_UNKNOWN; wf = 1'b0; end
                    endcase
                    // The flag goes in last, so VF as a target ends up holding it.
                    if (wf) begin
                        cpu_v[x] = res;
                        cpu_v[15] = {7'd0, f};
                    end
                end
                c8ie_pkg::GRP_SNER: begin
                    if (n != 4'h0) r.status = c8ie_pkg::ST_UNKNOWN;
                    else if (cpu_v[x] != cpu_v[y]) cpu_pc = cpu_pc + 12'd2;
                end
                c8ie_pkg::GRP_IDX: cpu_i = {4'h0, nnn};
                c8ie_pkg::GRP_JPV:
                    cpu_pc = nnn + {4'h0, (cpu_quirks ? cpu_v[0] : cpu_v[x])};
                c8ie_pkg::GRP_DRW: begin
                    r.drw = 1'b1;
                    r.dx = cpu_v[x];
                    r.dy = cpu_v[y];
                    r.dh = n;
                end
                c8ie_pkg::GRP_MISC: begin
                    case (nn)
                        c8ie_pkg::MISC_ADDI: cpu_i = cpu_i + {8'h0, cpu_v[x]};
                        c8ie_pkg::MISC_FONT:
                            cpu_i = 16'(GLYPH_START) + 16'd5 * {12'h0, cpu_v[x][3:0]};
                        c8ie_pkg::MISC_BCD: begin
                            cpu_mem[cpu_i[11:0]] = cpu_v[x] / 8'd100;
                            cpu_mem[cpu_i[11:0] + 12'd1] = (cpu_v[x] / 8'd10) % 8'd10;
                            cpu_mem[cpu_i[11:0] + 12'd2] = cpu_v[x] % 8'd10;
                        end
                        c8ie_pkg::MISC_STORE, c8ie_pkg::MISC_LOAD: begin
                            for (int k = 0; k <= x; k++) begin
                                if (nn == c8ie_pkg::MISC_STORE)
                                    cpu_mem[cpu_i[11:0] + 12'(k)] = cpu_v[k];
                                else cpu_v[k] = cpu_mem[cpu_i[11:0] + 12'(k)];
                            end
                            if (cpu_quirks) cpu_i = cpu_i + {12'h0, x} + 16'd1;
                        end
                        default: r.status = c8ie_pkg::ST_UNKNOWN;
                    endcase
                end
                default: r.status = c8ie_pkg::ST_UNKNOWN;
            endcase
            if (r.status == c8ie_pkg::ST_OVERFLOW) n_overflow++;
            if (r.status == c8ie_pkg::ST_UNDERFLOW) n_underflow++;
            if (r.status == c8ie_pkg::ST_UNKNOWN) n_unknown++;
        end
        r.pc = cpu_pc;
        r.idx = cpu_i;
        pending_items.push_back(it);
        expected_results.push_back(r);
        n_items++;
    endtask

    // Places an instruction at the current counter and runs it.
    task automatic run_word(input logic [15:0] w);
        queue_item(c8ie_pkg::OP_WRITE, cpu_pc, w[15:8]);
        queue_item(c8ie_pkg::OP_WRITE, cpu_pc + 12'd1, w[7:0]);
        queue_item(c8ie_pkg::OP_EXEC, $urandom, $urandom);
    endtask

    function automatic logic [15:0] random_word();
        logic [3:0]  x, y;
        logic [7:0]  nn;
        logic [11:0] nnn;
        logic [15:0] w;
        x = $urandom;
        y = $urandom;
        nn = $urandom;
        nnn = $urandom;
        case ($urandom_range(0, 21))
            0: w = {c8ie_pkg::GRP_SYS, c8ie_pkg::SYS_CLS};
            1, 2: w = {c8ie_pkg::GRP_SYS, c8ie_pkg::SYS_RET};
            3: w = {c8ie_pkg::GRP_SYS, nnn};
            4: w = {c8ie_pkg::GRP_JP, nnn};
            5: w = {c8ie_pkg::GRP_CALL, nnn};
            6: w = {c8ie_pkg::GRP_SEI, x, ($urandom_range(0, 1) ? cpu_v[x] : nn)};
            7: w = {c8ie_pkg::GRP_SNEI, x, ($urandom_range(0, 1) ? cpu_v[x] : nn)};
            8: w = {c8ie_pkg::GRP_SER, x, y, ($urandom_range(0, 3) == 0 ? nn[3:0] : 4'h0)};
            9: w = {c8ie_pkg::GRP_SNER, x, y, ($urandom_range(0, 3) == 0 ? nn[3:0] : 4'h0)};
            10, 11: w = {c8ie_pkg::GRP_LDI, x, nn};
            12: w = {c8ie_pkg::GRP_ADDI, x, nn};
            13, 14: w = {c8ie_pkg::GRP_ALU, x, y, nn[3:0]};
            15: w = {c8ie_pkg::GRP_IDX, nnn};
            16: w = {c8ie_pkg::GRP_JPV, nnn};
            17: w = {($urandom_range(0, 1) ? 4'hC : 4'hE), x, nn};
            18: w = {c8ie_pkg::GRP_DRW, x, y, nn[3:0]};
            19, 20: begin
                case ($urandom_range(0, 6))
                    0: nn = c8ie_pkg::MISC_ADDI;
                    1: nn = c8ie_pkg::MISC_FONT;
                    2: nn = c8ie_pkg::MISC_BCD;
                    3: nn = c8ie_pkg::MISC_STORE;
                    4: nn = c8ie_pkg::MISC_LOAD;
                    default: ;
                endcase
                w = {c8ie_pkg::GRP_MISC, x, nn};
            end
            default: w = $urandom;
        endcase
        return w;
    endfunction

    task automatic random_phase(input int count);
        int target;
        target = n_items + count;
        while (n_items < target) begin
            case ($urandom_range(0, 99))
                0, 1, 2, 3, 4, 5: queue_item(c8ie_pkg::OP_WRITE, $urandom, $urandom);
                6, 7, 8, 9: queue_item(c8ie_pkg::OP_READ, $urandom, $urandom);
                10, 11: queue_item(c8ie_pkg::OP_READ,
                                   cpu_i[11:0] + 12'($urandom_range(0, 15)), $urandom);
                12: queue_item(OP_NOP, $urandom, $urandom);
                13: begin
                    // Nested calls deep enough to hit the stack limit, then unwind.
                    n_calls++;
                    repeat (RET_DEPTH + 2) run_word({c8ie_pkg::GRP_CALL, 12'($urandom)});
                    repeat (RET_DEPTH + 2)
                        run_word({c8ie_pkg::GRP_SYS, c8ie_pkg::SYS_RET});
                end
                default: run_word(random_word());
            endcase
        end
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_quirks(input logic q);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= q;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cpu_quirks = q;
    endtask

    // Driver: bursts of items separated by random gaps.
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && !(i_in_valid && o_in_stall)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                {i_opcode, i_address, i_write_data} <= pending_items.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern: alternates between free flow, random and long stalls.
    int stall_mode = 0, mode_left = 0;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 2) == 0);
            default: i_out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // Monitor.
    always @(posedge i_clk) begin
        cpu_result_t got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_status, o_program_count, o_index_value, o_executed_word, o_read_data,
                   o_clear_screen, o_draw_request, o_draw_x, o_draw_y, o_draw_height};
            n_results++;
            if (expected_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("result with no item pending: %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("mismatch at result %0d:", n_results);
                        $display("  exp st=%0d pc=%h i=%h w=%h rd=%h cls=%b drw=%b x=%h y=%h n=%h",
                                 want.status, want.pc, want.idx, want.word, want.rd,
                                 want.clr, want.drw, want.dx, want.dy, want.dh);
                        $display("  got st=%0d pc=%h i=%h w=%h rd=%h cls=%b drw=%b x=%h y=%h n=%h",
                                 got.status, got.pc, got.idx, got.word, got.rd,
                                 got.clr, got.drw, got.dx, got.dy, got.dh);
                    end
                end
            end
        end
    end

    initial begin
        cpu_reset();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_quirks(1'b0);

        // Directed: reset contents, empty program, underflow, clear, draw, odd opcode.
        queue_item(c8ie_pkg::OP_READ, 12'(GLYPH_START), 8'h00);
        queue_item(c8ie_pkg::OP_READ, 12'(GLYPH_START + 79), 8'hFF);
        queue_item(c8ie_pkg::OP_READ, 12'hFFF, 8'h00);
        queue_item(c8ie_pkg::OP_EXEC, 12'h000, 8'h00);
        run_word({c8ie_pkg::GRP_SYS, c8ie_pkg::SYS_RET});
        run_word({c8ie_pkg::GRP_SYS, c8ie_pkg::SYS_CLS});
        run_word(16'hDFEF);
        queue_item(OP_NOP, 12'hFFF, 8'hFF);
        queue_item(c8ie_pkg::OP_WRITE, 12'hFFF, 8'hFF);
        queue_item(c8ie_pkg::OP_READ, 12'hFFF, 8'h00);
        run_word({c8ie_pkg::GRP_JP, 12'hFFF});
        drain();

        set_quirks(1'b1);
        random_phase(500);
        drain();
        set_quirks(1'b0);
        random_phase(500);
        drain();
        set_quirks(1'b1);
        random_phase(530);
        drain();
        repeat (50) @(posedge i_clk);

        if (expected_results.size() != 0) n_errors++;
        $display("%0d items, %0d results, %0d call bursts; stack overflows %0d, underflows %0d,",
                 n_items, n_results, n_calls, n_overflow, n_underflow);
        $display("%0d ignored instructions, both shift/store/jump quirk settings.", n_unknown);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
